// ===== sv/slcc_pkg.sv =====
// ----------------------------------------------------------------------------
// slcc_pkg
// Shared types and helpers for the segment/line cross classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package slcc_pkg;

  // Relation of segment A to line B
  typedef enum logic [1:0] {
    REL_ON    = 2'd0,
    REL_UP    = 2'd1,
    REL_DOWN  = 2'd2,
    REL_CROSS = 2'd3
  } rel_e;

  // Control bits that travel alongside the arithmetic
  typedef struct packed {
    logic valid;
    rel_e rel;
    logic dz;
    logic neg_x;
    logic neg_y;
  } ctrl_t;

  // Saturation bound on the quotient magnitude
  localparam int unsigned CLAMP_BIT = 40;

  // Combine the two endpoint classes
  function automatic rel_e rel_combine(rel_e r1, rel_e r2);
    rel_e r;
    if (r1 == r2) begin
      r = r1;
    end else if (r1 == REL_ON) begin
      r = r2;
    end else if (r2 == REL_ON) begin
      r = r1;
    end else begin
      r = REL_CROSS;
    end
    return r;
  endfunction

  // Saturate a 43-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(logic signed [42:0] v);
    logic signed [31:0] r;
    if (v > 43'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -43'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/slcc_front.sv =====
// ----------------------------------------------------------------------------
// slcc_front
// Classification and numerator/divisor set-up: five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module slcc_front #(
  parameter int N = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  wire [9:0]              tol_i,
  input  wire signed [N-1:0]     asx_i,
  input  wire signed [N-1:0]     asy_i,
  input  wire signed [N-1:0]     aex_i,
  input  wire signed [N-1:0]     aey_i,
  input  wire signed [N-1:0]     bsx_i,
  input  wire signed [N-1:0]     bsy_i,
  input  wire signed [N-1:0]     bex_i,
  input  wire signed [N-1:0]     bey_i,
  output slcc_pkg::ctrl_t        ctrl_o,
  output logic [3*N+5:0]         nmx_o,
  output logic [2*N+3:0]         dmx_o,
  output logic [3*N+5:0]         nmy_o,
  output logic [2*N+3:0]         dmy_o,
  output logic signed [N-1:0]    asx_o,
  output logic signed [N-1:0]    asy_o
);
  import slcc_pkg::*;

  localparam int D  = N + 1;     // coordinate differences
  localparam int P  = 2 * N + 2; // products of differences
  localparam int AW = 2 * N + 4; // numerator multiplicand a
  localparam int BW = N + 2;     // numerator multiplicand b
  localparam int NW = AW + BW;   // numerator
  localparam int DW = 2 * N + 4; // divisor

  logic [4:0] vld_q;

  // Stage 1: differences
  logic signed [D-1:0] o1x_d [2], o1y_d [2], o2x_d [2], o2y_d [2];
  logic signed [D-1:0] o1x_q [2], o1y_q [2], o2x_q [2], o2y_q [2];
  logic [1:0]          flip_d, flip_q;
  logic signed [D-1:0] x2_q, y2_q, x3_q, y3_q, x4_q, y4_q, dx43_q, dy43_q;
  logic signed [N-1:0] asx1_q, asy1_q;

  always_comb begin
    o1x_d[0] = D'(bsx_i) - D'(asx_i);
    o1y_d[0] = D'(bsy_i) - D'(asy_i);
    o2x_d[0] = D'(bex_i) - D'(asx_i);
    o2y_d[0] = D'(bey_i) - D'(asy_i);
    o1x_d[1] = D'(bsx_i) - D'(aex_i);
    o1y_d[1] = D'(bsy_i) - D'(aey_i);
    o2x_d[1] = D'(bex_i) - D'(aex_i);
    o2y_d[1] = D'(bey_i) - D'(aey_i);
    flip_d[0] = o1x_d[0] > o2x_d[0];
    flip_d[1] = o1x_d[1] > o2x_d[1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o1x_q  <= o1x_d;
      o1y_q  <= o1y_d;
      o2x_q  <= o2x_d;
      o2y_q  <= o2y_d;
      flip_q <= flip_d;
      x2_q   <= D'(aex_i) - D'(asx_i);
      y2_q   <= D'(aey_i) - D'(asy_i);
      x3_q   <= o1x_d[0];
      y3_q   <= o1y_d[0];
      x4_q   <= o2x_d[0];
      y4_q   <= o2y_d[0];
      dx43_q <= D'(bex_i) - D'(bsx_i);
      dy43_q <= D'(bey_i) - D'(bsy_i);
      asx1_q <= asx_i;
      asy1_q <= asy_i;
    end
  end

  // Stage 2: products
  logic signed [P-1:0] s1x_q [2], s1y_q [2], s2x_q [2], s2y_q [2];
  logic signed [P-1:0] m1_q [2], m2_q [2];
  logic [1:0]          flip2_q;
  logic signed [P-1:0] x3y4_q, x4y3_q, qa_q, qb_q, x3y2_q, y3x2_q;
  logic signed [D-1:0] x2b_q, y2b_q, x3b_q, y3b_q, dx43b_q, dy43b_q;
  logic signed [N-1:0] asx2_q, asy2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 2; k++) begin
        s1x_q[k] <= P'(o1x_q[k]) * P'(o1x_q[k]);
        s1y_q[k] <= P'(o1y_q[k]) * P'(o1y_q[k]);
        s2x_q[k] <= P'(o2x_q[k]) * P'(o2x_q[k]);
        s2y_q[k] <= P'(o2y_q[k]) * P'(o2y_q[k]);
        m1_q[k]  <= P'(o1x_q[k]) * P'(o2y_q[k]);
        m2_q[k]  <= P'(o2x_q[k]) * P'(o1y_q[k]);
      end
      flip2_q <= flip_q;
      x3y4_q  <= P'(x3_q) * P'(y4_q);
      x4y3_q  <= P'(x4_q) * P'(y3_q);
      qa_q    <= P'(y2_q) * P'(dx43_q);
      qb_q    <= P'(dy43_q) * P'(x2_q);
      x3y2_q  <= P'(x3_q) * P'(y2_q);
      y3x2_q  <= P'(y3_q) * P'(x2_q);
      x2b_q   <= x2_q;
      y2b_q   <= y2_q;
      x3b_q   <= x3_q;
      y3b_q   <= y3_q;
      dx43b_q <= dx43_q;
      dy43b_q <= dy43_q;
      asx2_q  <= asx1_q;
      asy2_q  <= asy1_q;
    end
  end

  // Stage 3: classify and pick the division operands
  logic signed [P:0]    tol_s;
  logic signed [P+1:0]  f_s [2];
  rel_e                 cls [2];
  rel_e                 rel_d;
  logic signed [P:0]    c_s, q_s;
  logic signed [AW-1:0] ax_d, ay_d;
  logic signed [BW-1:0] bx_d, by_d;
  logic signed [DW-1:0] dx_d, dy_d;
  logic                 dz_d;

  always_comb begin
    tol_s = $signed({{(P-9){1'b0}}, tol_i});
    for (int k = 0; k < 2; k++) begin
      f_s[k] = (P+2)'(m1_q[k]) - (P+2)'(m2_q[k]);
      if (flip2_q[k]) begin
        f_s[k] = -f_s[k];
      end
      if ((P+1)'(s1x_q[k]) <= tol_s && (P+1)'(s1y_q[k]) <= tol_s) begin
        cls[k] = REL_ON;
      end else if ((P+1)'(s2x_q[k]) <= tol_s && (P+1)'(s2y_q[k]) <= tol_s) begin
        cls[k] = REL_ON;
      end else if (f_s[k] <= (P+2)'(tol_s) && f_s[k] >= -(P+2)'(tol_s)) begin
        cls[k] = REL_ON;
      end else if (f_s[k] < 0) begin
        cls[k] = REL_UP;
      end else begin
        cls[k] = REL_DOWN;
      end
    end
    rel_d = rel_combine(cls[0], cls[1]);

    c_s  = (P+1)'(x3y4_q) - (P+1)'(x4y3_q);
    q_s  = (P+1)'(qa_q) - (P+1)'(qb_q);
    ax_d = '0;
    bx_d = BW'(1);
    dx_d = DW'(1);
    ay_d = '0;
    by_d = BW'(1);
    dy_d = DW'(1);
    dz_d = 1'b0;
    if (x2b_q == 0 && dx43b_q == 0) begin
      // both vertical: end of A
      ay_d = AW'(y2b_q);
    end else if (x2b_q == 0) begin
      // A vertical
      ay_d = -AW'(c_s);
      dy_d = DW'(dx43b_q);
    end else if (dx43b_q == 0) begin
      // B vertical
      ax_d = AW'(x3b_q);
      ay_d = AW'(x3y2_q);
      dy_d = DW'(x2b_q);
    end else if (y2b_q == 0 && dy43b_q == 0) begin
      // both horizontal: end of A
      ax_d = AW'(x2b_q);
    end else if (y2b_q == 0) begin
      // A horizontal
      ax_d = AW'(c_s);
      dx_d = DW'(dy43b_q);
    end else if (dy43b_q == 0) begin
      // B horizontal
      ax_d = AW'(y3x2_q);
      dx_d = DW'(y2b_q);
      ay_d = AW'(y3b_q);
    end else if (q_s == 0) begin
      dz_d = 1'b1;
    end else begin
      ax_d = -AW'(c_s);
      bx_d = BW'(x2b_q);
      dx_d = DW'(q_s);
      ay_d = -AW'(c_s);
      by_d = BW'(y2b_q);
      dy_d = DW'(q_s);
    end
  end

  rel_e                 rel3_q, rel4_q;
  logic                 dz3_q, dz4_q;
  logic signed [AW-1:0] ax_q, ay_q;
  logic signed [BW-1:0] bx_q, by_q;
  logic signed [DW-1:0] dx3_q, dy3_q, dx4_q, dy4_q;
  logic signed [N-1:0]  asx3_q, asy3_q, asx4_q, asy4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rel3_q <= rel_d;
      dz3_q  <= dz_d;
      ax_q   <= ax_d;
      bx_q   <= bx_d;
      dx3_q  <= dx_d;
      ay_q   <= ay_d;
      by_q   <= by_d;
      dy3_q  <= dy_d;
      asx3_q <= asx2_q;
      asy3_q <= asy2_q;
    end
  end

  // Stage 4: numerator products
  logic signed [NW-1:0] nx_q, ny_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q   <= NW'(ax_q) * NW'(bx_q);
      ny_q   <= NW'(ay_q) * NW'(by_q);
      rel4_q <= rel3_q;
      dz4_q  <= dz3_q;
      dx4_q  <= dx3_q;
      dy4_q  <= dy3_q;
      asx4_q <= asx3_q;
      asy4_q <= asy3_q;
    end
  end

  // Stage 5: sign and magnitude for the dividers
  rel_e rel5_q;
  logic dz5_q, negx5_q, negy5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmx_o   <= nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
      nmy_o   <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
      dmx_o   <= dx4_q[DW-1] ? DW'(-dx4_q) : DW'(dx4_q);
      dmy_o   <= dy4_q[DW-1] ? DW'(-dy4_q) : DW'(dy4_q);
      rel5_q  <= rel4_q;
      dz5_q   <= dz4_q;
      negx5_q <= nx_q[NW-1] ^ dx4_q[DW-1];
      negy5_q <= ny_q[NW-1] ^ dy4_q[DW-1];
      asx_o   <= asx4_q;
      asy_o   <= asy4_q;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  assign ctrl_o = '{valid: vld_q[4], rel: rel5_q, dz: dz5_q,
                    neg_x: negx5_q, neg_y: negy5_q};

endmodule

`default_nettype wire

// ===== sv/slcc_div.sv =====
// ----------------------------------------------------------------------------
// slcc_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
`default_nettype none

module slcc_div #(
  parameter int NW = 53,
  parameter int DW = 36,
  parameter int TW = 8
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           en_i,
  input  wire           valid_i,
  input  wire [NW-1:0]  num_i,
  input  wire [DW-1:0]  den_i,
  input  wire [TW-1:0]  tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [NW-1:0] vld_q;
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] sh_q  [NW];
  logic [DW-1:0] den_q [NW];
  logic [TW-1:0] tag_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW-1:0] rem_in, den_in;
    logic [NW-1:0] sh_in;
    logic [TW-1:0] tag_in;
    logic [DW:0]   t;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign sh_in  = num_i;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign sh_in  = sh_q[i-1];
      assign den_in = den_q[i-1];
      assign tag_in = tag_q[i-1];
    end

    // Trial subtract of the shifted remainder
    assign t    = {rem_in, sh_in[NW-1]};
    assign take = t >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= take ? DW'(t - {1'b0, den_in}) : t[DW-1:0];
        sh_q[i]  <= {sh_in[NW-2:0], take};
        den_q[i] <= den_in;
        tag_q[i] <= tag_in;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NW-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = sh_q[NW-1];
  assign tag_o   = tag_q[NW-1];

endmodule

`default_nettype wire

// ===== sv/segment_line_cross_classifier.sv =====
// ----------------------------------------------------------------------------
// segment_line_cross_classifier
// Classifies segment A against line B and computes the crossing point.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_stall_o  | a_*, b_* endpoints
//  out     | output    | out_valid_o/out_stall_i| relation, cross_x/y, divide_by_zero
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_data_i (on_tolerance)
//
//  One request enters per cycle while the output is not stalled; the path runs
//  through the two bit-per-stage dividers (3*COORD_BITS+6 stages) plus six stages.
//  Reset clears all valid bits and loads on_tolerance with 10.
//  A stalled result freezes the whole pipeline; nothing is dropped.
//  The configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_line_cross_classifier #(
  parameter int COORD_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [9:0]                    cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire signed [COORD_BITS-1:0]  a_start_x_i,
  input  wire signed [COORD_BITS-1:0]  a_start_y_i,
  input  wire signed [COORD_BITS-1:0]  a_end_x_i,
  input  wire signed [COORD_BITS-1:0]  a_end_y_i,
  input  wire signed [COORD_BITS-1:0]  b_start_x_i,
  input  wire signed [COORD_BITS-1:0]  b_start_y_i,
  input  wire signed [COORD_BITS-1:0]  b_end_x_i,
  input  wire signed [COORD_BITS-1:0]  b_end_y_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [1:0]                   relation_o,
  output logic signed [31:0]           cross_x_o,
  output logic signed [31:0]           cross_y_o,
  output logic                         divide_by_zero_o
);
  import slcc_pkg::*;

  localparam int N   = COORD_BITS;
  localparam int NW  = 3 * N + 6;
  localparam int DW  = 2 * N + 4;
  localparam int TXW = $bits(ctrl_t) + N;
  localparam int TYW = 1 + N;
  localparam int EW  = (NW > CLAMP_BIT + 1) ? NW : CLAMP_BIT + 1;

  logic       en;
  logic [9:0] tol_q;

  // Freeze the pipeline while a result waits
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // Hold the tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 10'd10;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  ctrl_t               fctrl;
  logic [NW-1:0]       nmx, nmy, qx, qy;
  logic [DW-1:0]       dmx, dmy;
  logic signed [N-1:0] fasx, fasy;

  slcc_front #(.N(N)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .tol_i   (tol_q),
    .asx_i   (a_start_x_i),
    .asy_i   (a_start_y_i),
    .aex_i   (a_end_x_i),
    .aey_i   (a_end_y_i),
    .bsx_i   (b_start_x_i),
    .bsy_i   (b_start_y_i),
    .bex_i   (b_end_x_i),
    .bey_i   (b_end_y_i),
    .ctrl_o  (fctrl),
    .nmx_o   (nmx),
    .dmx_o   (dmx),
    .nmy_o   (nmy),
    .dmy_o   (dmy),
    .asx_o   (fasx),
    .asy_o   (fasy)
  );

  logic           vx, vy;
  logic [TXW-1:0] tx;
  logic [TYW-1:0] ty;
  ctrl_t          dctrl;
  logic signed [N-1:0] dasx, dasy;
  logic           dnegy;

  slcc_div #(.NW(NW), .DW(DW), .TW(TXW)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fctrl.valid),
    .num_i   (nmx),
    .den_i   (dmx),
    .tag_i   ({fctrl, fasx}),
    .valid_o (vx),
    .quo_o   (qx),
    .tag_o   (tx)
  );

  slcc_div #(.NW(NW), .DW(DW), .TW(TYW)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fctrl.valid),
    .num_i   (nmy),
    .den_i   (dmy),
    .tag_i   ({fctrl.neg_y, fasy}),
    .valid_o (vy),
    .quo_o   (qy),
    .tag_o   (ty)
  );

  assign {dctrl, dasx} = tx;
  assign {dnegy, dasy} = ty;

  // Clamp, restore sign, add the origin and saturate
  function automatic logic signed [31:0] finish(logic [NW-1:0] q, logic neg,
                                                logic signed [N-1:0] org);
    logic [EW-1:0]        qe;
    logic [CLAMP_BIT:0]   cl;
    logic signed [41:0]   sv;
    logic signed [42:0]   sum;
    qe  = EW'(q);
    cl  = (qe > (EW'(1) << CLAMP_BIT)) ? (CLAMP_BIT + 1)'(1) << CLAMP_BIT
                                       : qe[CLAMP_BIT:0];
    sv  = $signed({1'b0, cl});
    if (neg) begin
      sv = -sv;
    end
    sum = 43'(sv) + 43'(org);
    return sat32(sum);
  endfunction

  logic pt_ok;
  assign pt_ok = (dctrl.rel == REL_CROSS) && !dctrl.dz;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vx && vy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      relation_o       <= dctrl.rel;
      cross_x_o        <= pt_ok ? finish(qx, dctrl.neg_x, dasx) : '0;
      cross_y_o        <= pt_ok ? finish(qy, dnegy, dasy) : '0;
      divide_by_zero_o <= (dctrl.rel == REL_CROSS) && dctrl.dz;
    end
  end

  // Checks
  a_no_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && relation_o != REL_CROSS |->
      cross_x_o == 0 && cross_y_o == 0 && !divide_by_zero_o)
    else $error("point reported without a crossing");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |->
      relation_o == REL_CROSS && cross_x_o == 0 && cross_y_o == 0)
    else $error("zero divisor with non-zero point");

  a_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vx == vy)
    else $error("divider lanes out of step");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives segment pairs into the cross classifier with random idling on both
// sides, predicts relation and crossing point per request and checks every
// result in order. The tolerance register is swept between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slcc_pkg::*;

  localparam int LATENCY    = 3 * 16 + 12;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD  = 300;

  typedef struct {
    logic signed [15:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  } seg_pair_t;

  typedef struct {
    rel_e               rel;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               dz;
  } crossing_t;

  // Holds the tolerance copy and the queue of predicted crossings
  class crossing_board;
    logic [9:0] tol = 10'd10;
    crossing_t  pending_q[$];
    int         errors = 0;

    function automatic rel_e side_of(longint px, longint py, longint b1x, longint b1y,
                                     longint b2x, longint b2y);
      longint x1, y1, x2, y2, t, f, lim;
      lim = longint'(tol);
      x1 = b1x - px; y1 = b1y - py;
      x2 = b2x - px; y2 = b2y - py;
      if (x1 * x1 <= lim && y1 * y1 <= lim) return REL_ON;
      if (x2 * x2 <= lim && y2 * y2 <= lim) return REL_ON;
      if (x1 > x2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      f = x1 * y2 - x2 * y1;
      if (f <= lim && f >= -lim) return REL_ON;
      return (f < 0) ? REL_UP : REL_DOWN;
    endfunction

    // Exact (a*b)/d truncated toward zero, magnitude clamped at 2^40
    function automatic longint scaled_div(longint a, longint b, longint d);
      logic [127:0] ma, mb, md, quot;
      logic         neg;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      md = (d < 0) ? -d : d;
      quot = (ma * mb) / md;
      if (quot > (128'd1 << 40)) quot = 128'd1 << 40;
      neg = ((a < 0) != (b < 0)) != (d < 0);
      return neg ? -longint'(quot) : longint'(quot);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_request(seg_pair_t s);
      crossing_t e;
      rel_e   r1, r2;
      longint x2, y2, x3, y3, x4, y4, px, py, c, q;
      r1 = side_of(s.asx, s.asy, s.bsx, s.bsy, s.bex, s.bey);
      r2 = side_of(s.aex, s.aey, s.bsx, s.bsy, s.bex, s.bey);
      if (r1 == r2) e.rel = r1;
      else if (r1 == REL_ON) e.rel = r2;
      else if (r2 == REL_ON) e.rel = r1;
      else e.rel = REL_CROSS;
      e.x = 0; e.y = 0; e.dz = 1'b0;
      if (e.rel == REL_CROSS) begin
        x2 = longint'(s.aex) - s.asx; y2 = longint'(s.aey) - s.asy;
        x3 = longint'(s.bsx) - s.asx; y3 = longint'(s.bsy) - s.asy;
        x4 = longint'(s.bex) - s.asx; y4 = longint'(s.bey) - s.asy;
        px = 0; py = 0;
        if (x2 == 0 && x4 == x3) begin
          py = y2;
        end else if (x2 == 0) begin
          py = scaled_div(y3 * x4 - y4 * x3, 1, x4 - x3);
        end else if (x4 == x3) begin
          px = x3;
          py = scaled_div(x3, y2, x2);
        end else if (y2 == 0 && y4 == y3) begin
          px = x2;
        end else if (y2 == 0) begin
          px = scaled_div(x3 * y4 - x4 * y3, 1, y4 - y3);
        end else if (y4 == y3) begin
          py = y3;
          px = scaled_div(y3, x2, y2);
        end else begin
          c = x3 * y4 - x4 * y3;
          q = y2 * (x4 - x3) - (y4 - y3) * x2;
          if (q == 0) begin
            e.dz = 1'b1;
          end else begin
            py = scaled_div(-c, y2, q);
            px = scaled_div(-c, x2, q);
          end
        end
        if (!e.dz) begin
          e.x = clamp32(px + s.asx);
          e.y = clamp32(py + s.asy);
        end
      end
      pending_q.push_back(e);
    endfunction

    function void check_result(crossing_t got);
      crossing_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result rel=%0d x=%0d y=%0d dz=%0b",
                 $realtime, got.rel, got.x, got.y, got.dz);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.rel != e.rel) begin
        $display("%0t: relation expected %0d actual %0d", $realtime, e.rel, got.rel);
        errors++;
      end
      if (got.x != e.x) begin
        $display("%0t: cross_x expected %0d actual %0d", $realtime, e.x, got.x);
        errors++;
      end
      if (got.y != e.y) begin
        $display("%0t: cross_y expected %0d actual %0d", $realtime, e.y, got.y);
        errors++;
      end
      if (got.dz != e.dz) begin
        $display("%0t: divide_by_zero expected %0b actual %0b", $realtime, e.dz, got.dz);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [9:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic signed [15:0] asx_d = '0, asy_d = '0, aex_d = '0, aey_d = '0;
  logic signed [15:0] bsx_d = '0, bsy_d = '0, bex_d = '0, bey_d = '0;
  wire cfg_ready_o, in_stall_o, out_valid_o, divide_by_zero_o;
  wire [1:0] relation_o;
  wire signed [31:0] cross_x_o, cross_y_o;

  crossing_board board = new();
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  segment_line_cross_classifier #(.COORD_BITS(16)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .a_start_x_i(asx_d), .a_start_y_i(asy_d), .a_end_x_i(aex_d), .a_end_y_i(aey_d),
    .b_start_x_i(bsx_d), .b_start_y_i(bsy_d), .b_end_x_i(bex_d), .b_end_y_i(bey_d),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .relation_o(relation_o), .cross_x_o(cross_x_o), .cross_y_o(cross_y_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  // Sample results on the falling clock edge, before the rising edge that takes them
  always @(negedge clk_i) begin
    crossing_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.rel = rel_e'(relation_o);
      got.x = cross_x_o;
      got.y = cross_y_o;
      got.dz = divide_by_zero_o;
      board.check_result(got);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("segment_line_cross_classifier test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one request and hold it until taken, then maybe idle
  task automatic send_pair(seg_pair_t s);
    asx_d <= s.asx; asy_d <= s.asy; aex_d <= s.aex; aey_d <= s.aey;
    bsx_d <= s.bsx; bsy_d <= s.bsy; bex_d <= s.bex; bey_d <= s.bey;
    in_valid_i <= 1'b1;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    board.note_request(s);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Write the tolerance with the pipe empty
  task automatic write_tolerance(logic [9:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    board.tol = v;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic seg_pair_t mk(int a0, int a1, int a2, int a3,
                                   int b0, int b1, int b2, int b3);
    seg_pair_t s;
    s.asx = 16'(a0); s.asy = 16'(a1); s.aex = 16'(a2); s.aey = 16'(a3);
    s.bsx = 16'(b0); s.bsy = 16'(b1); s.bex = 16'(b2); s.bey = 16'(b3);
    return s;
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t s;
    int k, d;
    k = $urandom_range(0, 9);
    if (k < 3) begin
      // full-range noise
      s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (k < 6) begin
      // small coordinates, so the tolerance matters
      s = mk(int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20,
             int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20,
             int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20,
             int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20);
    end else if (k < 8) begin
      // A straddles B roughly at right angles
      d = $urandom_range(1, 30000);
      s = mk(-d, int'($urandom_range(0, 200)) - 100, d, int'($urandom_range(0, 200)) - 100,
             int'($urandom_range(0, 200)) - 100, -d, int'($urandom_range(0, 200)) - 100, d);
    end else begin
      // near-parallel long lines, large quotients
      s = mk(-32768, -32000, 32767, 32000 + int'($urandom_range(0, 60)),
             -32768, -31900, 32767, 32100 - int'($urandom_range(0, 300)));
    end
    return s;
  endfunction

  initial begin
    seg_pair_t dir_q[$];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, on, up, down, vertical and horizontal cases
    dir_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    dir_q.push_back(mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
    dir_q.push_back(mk(0, 5, 10, 5, 0, 0, 10, 0));
    dir_q.push_back(mk(0, -5, 10, -5, 0, 0, 10, 0));
    dir_q.push_back(mk(1, 1, 50, 50, 0, 0, 10, 0));
    dir_q.push_back(mk(5, -10, 5, 10, -10, 0, 10, 0));
    dir_q.push_back(mk(0, -10, 0, 10, 7, -20, 7, 20));
    dir_q.push_back(mk(-10, -10, 0, 10, -100, -3, 100, 5));
    dir_q.push_back(mk(-10, -7, 10, 9, 3, -100, 3, 100));
    dir_q.push_back(mk(-10, 4, 10, 4, -50, -30, 60, 40));
    dir_q.push_back(mk(-10, -30, 10, 40, -50, 4, 60, 4));
    dir_q.push_back(mk(-20, -20, 30, 25, -20, 25, 30, -20));
    dir_q.push_back(mk(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
    dir_q.push_back(mk(-32768, 0, 32767, 1, -32768, 2, 32767, -1));
    dir_q.push_back(mk(-32768, -32767, 32767, 32766, -32768, -32766, 32767, 32767));
    dir_q.push_back(mk(0, 0, 40, 0, 2, 2, 40, 30));
    foreach (dir_q[i]) send_pair(dir_q[i]);

    // Random phases over several tolerances, long hold in the first
    write_tolerance(10'd0);
    long_hold_req = 1'b1;
    repeat (100) send_pair(rand_pair());
    write_tolerance(10'd1023);
    repeat (100) send_pair(rand_pair());
    write_tolerance(10'($urandom_range(1, 1022)));
    repeat (100) send_pair(rand_pair());
    write_tolerance(10'd10);
    quiet = 1'b1;
    repeat (80) send_pair(rand_pair());
    drain();

    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("segment_line_cross_classifier test passed");
    end else begin
      $display("segment_line_cross_classifier test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== segment_line_cross_classifier.f =====
sv/slcc_pkg.sv
sv/slcc_front.sv
sv/slcc_div.sv
sv/segment_line_cross_classifier.sv
tb/sv/tb_top.sv
